### rtl/spma_pkg.sv
// shared types and constants for the sparse polynomial multiply and add core
// no dependencies
`default_nettype none

package spma_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_SCAN
	} state_t;

	localparam logic [2:0] MODE_LOAD_FIRST  = 3'd0;
	localparam logic [2:0] MODE_LOAD_SECOND = 3'd1;
	localparam logic [2:0] MODE_FETCH_PROD  = 3'd2;
	localparam logic [2:0] MODE_FETCH_SUM   = 3'd3;
	localparam logic [2:0] MODE_CLEAR       = 3'd4;

	localparam int COEF_W     = 16;
	localparam int EXP_W      = 10;
	localparam int ACC_W      = 32;
	localparam int OUT_EXP_W  = 11;

endpackage

`default_nettype wire

### rtl/sparse_polynomial_mul_add_core.sv
// sparse polynomial multiply and add core: term list, dense product and sum stores
// depends on spma_pkg
//
//  channel | direction | signals                                       | transfer when
//  --------+-----------+-----------------------------------------------+-----------------------
//  in      | input     | in_valid, in_stall, mode, term_coef,          | in_valid && !in_stall
//          |           | term_exponent                                 |
//  out     | output    | out_valid, out_stall, out_coef, out_exponent, | out_valid && !out_stall
//          |           | end_of_terms                                  |
//
// first term load: accept, then the sum store read-modify-write
// second term load: accept, sum store update, then the product loop, which streams one stored
//   first term per cycle through the product store port, forwarding on back-to-back hits
// fetch: the walk visits one store entry per cycle on the store read port;
//   a fetch past the end returns its end mark without a walk
// after reset and after a clear item the stores are zeroed in the ST_CLEAR walk,
//   during which in_stall is high
// a result waiting on out_stall blocks only the next fetch; loads and clears still go in
`default_nettype none

module sparse_polynomial_mul_add_core #(
	parameter int MAX_EXPONENTS = 1024,
	parameter int MAX_TERMS     = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [2:0]               mode,
	input  wire logic signed [15:0]       term_coef,
	input  wire logic [9:0]               term_exponent,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [31:0]            out_coef,
	output logic [10:0]                   out_exponent,
	output logic                          end_of_terms
);

	localparam int PROD_SIZE = 2 * MAX_EXPONENTS - 1;
	localparam int PAW       = $clog2(PROD_SIZE);
	localparam int EW        = $clog2(MAX_EXPONENTS);
	localparam int TAW       = $clog2(MAX_TERMS);
	localparam int CW        = $clog2(MAX_TERMS + 1);
	localparam int FTW       = spma_pkg::COEF_W + EW;
	localparam int AW        = spma_pkg::ACC_W;

	// storage
	logic [FTW-1:0] ft_mem   [MAX_TERMS];
	logic [AW-1:0]  prod_mem [PROD_SIZE];
	logic [AW-1:0]  sum_mem  [MAX_EXPONENTS];

	spma_pkg::state_t state_q, state_d;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  mk_q;
	logic [PAW-1:0] clr_q;
	logic [PAW-1:0] pcur_q;
	logic           pdone_q;
	logic [EW-1:0]  scur_q;
	logic           sdone_q;

	logic signed [15:0] lcoef_q;
	logic [EW-1:0]      lexp_q;
	logic               lmul_q;
	logic               scan_sum_q;
	logic [PAW-1:0]     scan_addr_q;

	// product loop pipeline
	logic               v_s1, v_s2;
	logic [FTW-1:0]     ft_rd_s1;
	logic signed [31:0] p_s2;
	logic [PAW-1:0]     addr_s2;
	logic               fwd_hit_s2;
	logic [AW-1:0]      fwd_data_q;

	logic [AW-1:0] prod_rd_q;
	logic [AW-1:0] sum_rd_q;

	logic               out_valid_q;
	logic signed [31:0] out_coef_q;
	logic [10:0]        out_exponent_q;
	logic               end_q;

	// memory port controls
	logic           ft_we;
	logic [TAW-1:0] ft_ra;
	logic           prod_we;
	logic [PAW-1:0] prod_wa, prod_ra;
	logic [AW-1:0]  prod_wd;
	logic           sum_we;
	logic [EW-1:0]  sum_wa, sum_ra;
	logic [AW-1:0]  sum_wd;

	logic               accept;
	logic               is_fetch;
	logic               exp_ok;
	logic               load_ok;
	logic               out_free;
	logic               out_set;
	logic               sel_done;
	logic signed [15:0] ft_coef_s1;
	logic [EW-1:0]      ft_exp_s1;
	logic [PAW-1:0]     addr_s1;
	logic signed [31:0] mul_s1;
	logic [AW-1:0]      base_s2;
	logic [AW-1:0]      acc_s2;
	logic [AW-1:0]      scan_data;
	logic               scan_hit;
	logic               scan_last;
	logic [PAW-1:0]     scan_prev;
	logic               clr_last;
	logic               issue;
	logic               mul_done;

	assign accept    = in_valid && !in_stall;
	assign is_fetch  = (mode == spma_pkg::MODE_FETCH_PROD) || (mode == spma_pkg::MODE_FETCH_SUM);
	assign exp_ok    = 32'(term_exponent) < 32'(MAX_EXPONENTS);
	assign load_ok   = count_q < CW'(MAX_TERMS);
	assign out_free  = !out_valid_q || !out_stall;
	assign sel_done  = (mode == spma_pkg::MODE_FETCH_SUM) ? sdone_q : pdone_q;

	assign ft_coef_s1 = ft_rd_s1[FTW-1:EW];
	assign ft_exp_s1  = ft_rd_s1[EW-1:0];
	assign addr_s1    = PAW'(ft_exp_s1) + PAW'(lexp_q);
	assign mul_s1     = 32'(lcoef_q) * 32'(ft_coef_s1);
	// the entry written last cycle is not yet visible in the registered read data
	assign base_s2    = fwd_hit_s2 ? fwd_data_q : prod_rd_q;
	assign acc_s2     = base_s2 + p_s2;

	assign scan_data = scan_sum_q ? sum_rd_q : prod_rd_q;
	assign scan_hit  = scan_data != '0;
	assign scan_last = scan_addr_q == '0;
	assign scan_prev = scan_addr_q - PAW'(1);
	assign clr_last  = clr_q == '0;
	assign issue     = mk_q < count_q;
	assign mul_done  = !issue && !v_s1 && !v_s2;

	// exhausted cursor answers with the end mark at once, otherwise the walk ends it
	assign out_set = (accept && is_fetch && sel_done)
		|| (state_q == spma_pkg::ST_SCAN && (scan_hit || scan_last));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spma_pkg::ST_CLEAR: begin
				if (clr_last) state_d = spma_pkg::ST_IDLE;
			end
			spma_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						spma_pkg::MODE_LOAD_FIRST: begin
							if (exp_ok && load_ok) state_d = spma_pkg::ST_SUM;
						end
						spma_pkg::MODE_LOAD_SECOND: begin
							if (exp_ok) state_d = spma_pkg::ST_SUM;
						end
						spma_pkg::MODE_FETCH_PROD: begin
							if (!pdone_q) state_d = spma_pkg::ST_SCAN;
						end
						spma_pkg::MODE_FETCH_SUM: begin
							if (!sdone_q) state_d = spma_pkg::ST_SCAN;
						end
						spma_pkg::MODE_CLEAR: state_d = spma_pkg::ST_CLEAR;
						default: ;
					endcase
				end
			end
			spma_pkg::ST_SUM: begin
				state_d = (lmul_q && count_q != '0) ? spma_pkg::ST_MUL : spma_pkg::ST_IDLE;
			end
			spma_pkg::ST_MUL: begin
				if (mul_done) state_d = spma_pkg::ST_IDLE;
			end
			spma_pkg::ST_SCAN: begin
				if (scan_hit || scan_last) state_d = spma_pkg::ST_IDLE;
			end
			default: state_d = spma_pkg::ST_CLEAR;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		in_stall = 1'b1;
		ft_we    = 1'b0;
		ft_ra    = TAW'(mk_q);
		prod_we  = 1'b0;
		prod_wa  = clr_q;
		prod_wd  = '0;
		prod_ra  = pcur_q;
		sum_we   = 1'b0;
		sum_wa   = lexp_q;
		sum_wd   = '0;
		sum_ra   = scur_q;
		unique case (state_q)
			spma_pkg::ST_CLEAR: begin
				prod_we = 1'b1;
				sum_we  = 32'(clr_q) < 32'(MAX_EXPONENTS);
				sum_wa  = EW'(clr_q);
			end
			spma_pkg::ST_IDLE: begin
				in_stall = is_fetch && !out_free;
				ft_we    = accept && (mode == spma_pkg::MODE_LOAD_FIRST) && exp_ok && load_ok;
				sum_ra   = (mode == spma_pkg::MODE_FETCH_SUM) ? scur_q : EW'(term_exponent);
			end
			spma_pkg::ST_SUM: begin
				sum_we = 1'b1;
				sum_wd = sum_rd_q + AW'(lcoef_q);
			end
			spma_pkg::ST_MUL: begin
				prod_ra = addr_s1;
				prod_we = v_s2;
				prod_wa = addr_s2;
				prod_wd = acc_s2;
			end
			spma_pkg::ST_SCAN: begin
				prod_ra = scan_prev;
				sum_ra  = EW'(scan_prev);
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (ft_we) ft_mem[TAW'(count_q)] <= {term_coef, EW'(term_exponent)};
		ft_rd_s1 <= ft_mem[ft_ra];
	end

	always_ff @(posedge clk) begin
		if (prod_we) prod_mem[prod_wa] <= prod_wd;
		prod_rd_q <= prod_mem[prod_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spma_pkg::ST_CLEAR;
			clr_q       <= PAW'(PROD_SIZE - 1);
			count_q     <= '0;
			mk_q        <= '0;
			pcur_q      <= PAW'(PROD_SIZE - 1);
			pdone_q     <= 1'b0;
			scur_q      <= EW'(MAX_EXPONENTS - 1);
			sdone_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fwd_hit_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			v_s1       <= (state_q == spma_pkg::ST_MUL) && issue;
			v_s2       <= v_s1;
			fwd_hit_s2 <= v_s1 && v_s2 && (addr_s1 == addr_s2);
			if (out_set) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				spma_pkg::ST_CLEAR: begin
					clr_q <= clr_last ? PAW'(PROD_SIZE - 1) : clr_q - PAW'(1);
				end
				spma_pkg::ST_IDLE: begin
					mk_q <= '0;
					if (accept) begin
						unique case (mode)
							spma_pkg::MODE_LOAD_FIRST: begin
								if (exp_ok && load_ok) begin
									count_q <= count_q + CW'(1);
									pcur_q  <= PAW'(PROD_SIZE - 1);
									pdone_q <= 1'b0;
									scur_q  <= EW'(MAX_EXPONENTS - 1);
									sdone_q <= 1'b0;
								end
							end
							spma_pkg::MODE_LOAD_SECOND: begin
								if (exp_ok) begin
									pcur_q  <= PAW'(PROD_SIZE - 1);
									pdone_q <= 1'b0;
									scur_q  <= EW'(MAX_EXPONENTS - 1);
									sdone_q <= 1'b0;
								end
							end
							spma_pkg::MODE_CLEAR: begin
								count_q <= '0;
								pcur_q  <= PAW'(PROD_SIZE - 1);
								pdone_q <= 1'b0;
								scur_q  <= EW'(MAX_EXPONENTS - 1);
								sdone_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				spma_pkg::ST_MUL: begin
					if (issue) mk_q <= mk_q + CW'(1);
				end
				spma_pkg::ST_SCAN: begin
					if (scan_hit || scan_last) begin
						if (scan_sum_q) begin
							if (scan_last) sdone_q <= 1'b1;
							else scur_q <= EW'(scan_prev);
						end else begin
							if (scan_last) pdone_q <= 1'b1;
							else pcur_q <= scan_prev;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		p_s2       <= mul_s1;
		addr_s2    <= addr_s1;
		fwd_data_q <= acc_s2;

		if (accept) begin
			lcoef_q     <= term_coef;
			lexp_q      <= EW'(term_exponent);
			lmul_q      <= mode == spma_pkg::MODE_LOAD_SECOND;
			scan_sum_q  <= mode == spma_pkg::MODE_FETCH_SUM;
			scan_addr_q <= (mode == spma_pkg::MODE_FETCH_SUM) ? PAW'(scur_q) : pcur_q;
		end else if (state_q == spma_pkg::ST_SCAN && !scan_hit && !scan_last) begin
			scan_addr_q <= scan_prev;
		end

		if (accept && is_fetch && sel_done) begin
			out_coef_q     <= '0;
			out_exponent_q <= '0;
			end_q          <= 1'b1;
		end else if (state_q == spma_pkg::ST_SCAN) begin
			if (scan_hit) begin
				out_coef_q     <= scan_data;
				out_exponent_q <= 11'(scan_addr_q);
				end_q          <= 1'b0;
			end else if (scan_last) begin
				out_coef_q     <= '0;
				out_exponent_q <= '0;
				end_q          <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_coef     = out_coef_q;
	assign out_exponent = out_exponent_q;
	assign end_of_terms = end_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TERMS))
		else $error("first term count beyond capacity");

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != spma_pkg::ST_MUL) |-> (!v_s1 && !v_s2))
		else $error("product pipeline busy outside the product loop");

	a_fetch_room: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_fetch) |-> (!out_valid_q || !out_stall))
		else $error("fetch taken while a result is held");

	a_end_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> (out_coef_q == '0 && out_exponent_q == '0))
		else $error("end mark carries a nonzero term");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spma_pkg::ST_SCAN && (scan_hit || scan_last)) |=> out_valid_q)
		else $error("finished walk produced no result");

endmodule

`default_nettype wire
